### rtl/telnet_iac_stripper_defines.svh
// ----------------------------------------------------------------------------
// telnet_iac_stripper_defines - assertion macros
// Concurrent assertion helpers shared by the telnet filter sources.
// ----------------------------------------------------------------------------
`ifndef TELNET_IAC_STRIPPER_DEFINES_SVH
`define TELNET_IAC_STRIPPER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define TIS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("implication check failed");

// next-cycle implication, checked out of reset
`define TIS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");

`else

`define TIS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define TIS_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

### rtl/tis_pkg.sv
// ----------------------------------------------------------------------------
// tis_pkg - telnet filter package
// Protocol codes, counter limits, parser phases and item types.
// ----------------------------------------------------------------------------
package tis_pkg;

	// buffer size and kept-byte counter
	localparam int unsigned BUFFER_BYTES = 1024;
	localparam int unsigned CNT_W        = 11;
	localparam int unsigned FIELD_MAX    = (1 << CNT_W) - 1;
	localparam int unsigned KEEP_LIMIT   =
		(BUFFER_BYTES > FIELD_MAX) ? FIELD_MAX : BUFFER_BYTES;
	localparam logic [CNT_W-1:0] KEEP_LIMIT_C = CNT_W'(KEEP_LIMIT);

	// telnet and terminal codes
	localparam logic [7:0] CODE_IAC  = 8'hFF;
	localparam logic [7:0] CODE_NOP  = 8'hF1;
	localparam logic [7:0] CODE_SB   = 8'hFA;
	localparam logic [7:0] CODE_NAWS = 8'h1F;
	localparam logic [7:0] CODE_CR   = 8'h0D;
	localparam logic [7:0] CODE_LF   = 8'h0A;
	localparam logic [7:0] CODE_NUL  = 8'h00;

	// window-size payload length after IAC SB NAWS
	localparam int unsigned SKIP_W       = 3;
	localparam logic [SKIP_W-1:0] NAWS_PAYLOAD = SKIP_W'(6);

	// stream widths
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	// parser phases
	typedef enum logic [4:0] {
		PH_DATA    = 5'b00001,
		PH_IAC     = 5'b00010,
		PH_IAC_SB  = 5'b00100,
		PH_IAC_CMD = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	// one received byte
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_last;
	} in_item_t;

	// one filter result
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             data_valid;
		logic             buffer_done;
		logic [CNT_W-1:0] kept_total;
	} result_t;

endpackage

### rtl/tis_in_stage.sv
// ----------------------------------------------------------------------------
// tis_in_stage - input register
// Holds one received byte for the parser; refills in the cycle it is used.
// ----------------------------------------------------------------------------
module tis_in_stage
	import tis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     valid_s1,
	input  logic     take,
	output in_item_t item_s1
);

	// free when empty or being consumed this cycle
	assign in_ready = !valid_s1 || take;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, loaded on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/tis_parser.sv
// ----------------------------------------------------------------------------
// tis_parser - telnet command parser
// Tracks IAC sequences, CR pairs and the kept-byte count for one byte a step.
// ----------------------------------------------------------------------------
module tis_parser
	import tis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output logic     has_result,
	output result_t  result
);

	phase_t              phase_q, phase_d;
	logic [SKIP_W-1:0]   skip_q, skip_d, skip_dec;
	logic                cr_q, cr_d;
	logic [CNT_W-1:0]    kept_q, kept_d, kept_inc;
	logic                keep;
	logic [7:0]          out_byte;
	logic                pair_drop;
	logic [7:0]          b;

	assign b         = item.rx_byte;
	assign skip_dec  = (skip_q != '0) ? skip_q - SKIP_W'(1) : skip_q;
	assign pair_drop = cr_q && ((b == CODE_LF) || (b == CODE_NUL));

	// next phase and kept byte
	always_comb begin
		phase_d  = phase_q;
		skip_d   = skip_q;
		cr_d     = 1'b0;
		keep     = 1'b0;
		out_byte = 8'h00;
		unique case (phase_q)
			PH_IAC: begin
				if (b == CODE_NOP) begin
					phase_d = PH_DATA;
				end else if (b == CODE_IAC) begin
					keep     = 1'b1;
					out_byte = CODE_IAC;
					phase_d  = PH_DATA;
				end else if (b == CODE_SB) begin
					phase_d = PH_IAC_SB;
				end else begin
					phase_d = PH_IAC_CMD;
				end
			end
			PH_IAC_SB: begin
				if (b == CODE_NAWS) begin
					skip_d  = NAWS_PAYLOAD;
					phase_d = PH_SKIP;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_IAC_CMD: begin
				phase_d = PH_DATA;
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d = PH_DATA;
				end
			end
			default: begin
				// plain data; LF or NUL right after a kept CR is dropped
				phase_d = PH_DATA;
				if (!pair_drop) begin
					if (b == CODE_IAC) begin
						phase_d = PH_IAC;
					end else begin
						keep     = 1'b1;
						out_byte = b;
						cr_d     = (b == CODE_CR);
					end
				end
			end
		endcase

		// saturating count of kept bytes
		kept_inc = kept_q;
		if (keep && (kept_q < KEEP_LIMIT_C)) begin
			kept_inc = kept_q + CNT_W'(1);
		end
		kept_d = kept_inc;

		// buffer end drops open sequences and restarts the count
		if (item.buffer_last) begin
			phase_d = PH_DATA;
			skip_d  = '0;
			cr_d    = 1'b0;
			kept_d  = '0;
		end
	end

	// result of this byte
	assign has_result         = keep || item.buffer_last;
	assign result.data_byte   = out_byte;
	assign result.data_valid  = keep;
	assign result.buffer_done = item.buffer_last;
	assign result.kept_total  = kept_inc;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			skip_q  <= '0;
			cr_q    <= 1'b0;
			kept_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			cr_q    <= cr_d;
			kept_q  <= kept_d;
		end
	end

endmodule

### rtl/tis_out_stage.sv
// ----------------------------------------------------------------------------
// tis_out_stage - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tis_out_stage
	import tis_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	output logic    load_ready,
	input  result_t res_in,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	// free when empty or being taken this cycle
	assign load_ready = !out_valid || out_ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

### rtl/telnet_iac_stripper.sv
// ----------------------------------------------------------------------------
// telnet_iac_stripper - telnet receive filter
// Strips IAC commands and CR pair bytes, reports kept bytes per buffer.
// ----------------------------------------------------------------------------
// channel  dir  tdata                              tlast        tuser
// s_*      in   [7:0] rx_byte                      buffer_last  -
// m_*      out  [7:0] data_byte, [18:8] kept_total buffer_done  data_valid
//
// one byte enters per clock unless a full result register stalls it; its result
// passes the input register, then the result register, before it can transfer.
// a byte that yields no result (dropped, not a buffer end) only updates state.
// a stalled result register holds the parser and input register in place.
// arst_n clears all valid flags, the parse phase, CR flag and kept count.
// ----------------------------------------------------------------------------
`include "telnet_iac_stripper_defines.svh"

module telnet_iac_stripper
	import tis_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [18:8] kept_total
	output logic                   m_tlast,
	output logic                   m_tuser    // [0] data_valid
);

	in_item_t in_item, item_s1;
	logic     valid_s1;
	logic     advance;
	logic     has_result;
	logic     load_ready;
	result_t  res_d, res_q;

	// input transfer payload
	assign in_item.rx_byte     = s_tdata[7:0];
	assign in_item.buffer_last = s_tlast;

	tis_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.take     (advance),
		.item_s1  (item_s1)
	);

	// a byte moves on unless its result finds the output register full and not being taken
	assign advance = valid_s1 && (!has_result || load_ready);

	tis_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.has_result (has_result),
		.result     (res_d)
	);

	tis_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && has_result),
		.load_ready (load_ready),
		.res_in     (res_d),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.res_q      (res_q)
	);

	// output transfer payload
	assign m_tdata = {{(OUT_TDATA_W - 8 - CNT_W){1'b0}}, res_q.kept_total, res_q.data_byte};
	assign m_tlast = res_q.buffer_done;
	assign m_tuser = res_q.data_valid;

	// a result without a kept byte only exists for a buffer end
	`TIS_ASSERT_IMPLIES(a_empty_is_end, clk, arst_n, m_tvalid && !m_tuser, m_tlast)
	// an empty result carries a zero byte
	`TIS_ASSERT_IMPLIES(a_empty_zero, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata[7:0] == 8'h00)
	// a kept byte always shows a nonzero count
	`TIS_ASSERT_IMPLIES(a_kept_count, clk, arst_n, m_tvalid && m_tuser,
		m_tdata[18:8] != '0)
	// a held byte stays in the input register
	`TIS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - telnet receive filter test
// Drives telnet byte streams into the filter under several idle and stall
// mixes and checks every result against a cycle-free software copy of the
// parser. Covers directed corner cases and random command sequences.
// ----------------------------------------------------------------------------
module testbench;
	import tis_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned MAX_REPORTS    = 10;

	// kinds of random stream fragments
	typedef enum int {
		FR_TEXT, FR_CR_PAIR, FR_IAC_NOP, FR_IAC_IAC,
		FR_NAWS, FR_SB_OTHER, FR_IAC_CMD, FR_NOISE
	} frag_kind_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;

	// stimulus and expectation stores
	in_item_t rx_stream_q[$];
	result_t  filtered_q[$];
	in_item_t cur_byte;
	bit       byte_taken;
	int       bytes_queued;
	int       bytes_taken;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       mismatches;
	int       stuck_cycles;

	// parser state copy
	phase_t            parse_phase = PH_DATA;
	logic [SKIP_W-1:0] skip_left   = '0;
	logic              after_cr    = 1'b0;
	logic [CNT_W-1:0]  kept_count  = '0;

	telnet_iac_stripper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// advance the parser by one byte and queue the result it causes
	task automatic filter_byte(input in_item_t it);
		logic       was_cr;
		logic       keep;
		logic [7:0] outb;
		result_t    r;
		was_cr   = after_cr;
		after_cr = 1'b0;
		keep     = 1'b0;
		outb     = '0;
		case (parse_phase)
			PH_IAC: begin
				if (it.rx_byte == CODE_NOP) begin
					parse_phase = PH_DATA;
				end else if (it.rx_byte == CODE_IAC) begin
					keep        = 1'b1;
					outb        = CODE_IAC;
					parse_phase = PH_DATA;
				end else begin
					parse_phase = (it.rx_byte == CODE_SB) ? PH_IAC_SB : PH_IAC_CMD;
				end
			end
			PH_IAC_SB: begin
				if (it.rx_byte == CODE_NAWS) begin
					skip_left   = NAWS_PAYLOAD;
					parse_phase = PH_SKIP;
				end else begin
					parse_phase = PH_DATA;
				end
			end
			PH_IAC_CMD: parse_phase = PH_DATA;
			PH_SKIP: begin
				if (skip_left != 0)
					skip_left = skip_left - 1'b1;
				if (skip_left == 0)
					parse_phase = PH_DATA;
			end
			default: begin
				parse_phase = PH_DATA;
				if (was_cr && (it.rx_byte == CODE_LF || it.rx_byte == CODE_NUL)) begin
					// second byte of a CR pair is dropped
				end else if (it.rx_byte == CODE_IAC) begin
					parse_phase = PH_IAC;
				end else begin
					keep     = 1'b1;
					outb     = it.rx_byte;
					after_cr = (it.rx_byte == CODE_CR);
				end
			end
		endcase
		if (keep && kept_count < KEEP_LIMIT_C)
			kept_count = kept_count + 1'b1;
		if (keep || it.buffer_last) begin
			r.data_byte   = outb;
			r.data_valid  = keep;
			r.buffer_done = it.buffer_last;
			r.kept_total  = kept_count;
			filtered_q.push_back(r);
		end
		// buffer end drops any open sequence and the CR memory, and restarts the count
		if (it.buffer_last) begin
			parse_phase = PH_DATA;
			skip_left   = '0;
			after_cr    = 1'b0;
			kept_count  = '0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.rx_byte     = b;
		it.buffer_last = last;
		rx_stream_q.push_back(it);
		bytes_queued++;
	endtask

	// byte with a random buffer end now and then
	task automatic add_byte(input logic [7:0] b);
		push_byte(b, $urandom_range(15) == 0);
	endtask

	task automatic gen_random(input int count);
		int         start;
		int         n;
		frag_kind_t kind;
		logic [7:0] b;
		start = bytes_queued;
		while (bytes_queued - start < count) begin
			kind = frag_kind_t'($urandom_range(int'(FR_NOISE)));
			case (kind)
				FR_TEXT: begin
					n = $urandom_range(1, 6);
					repeat (n) add_byte(8'($urandom_range(0, 8'hFE)));
				end
				FR_CR_PAIR: begin
					add_byte(CODE_CR);
					case ($urandom_range(2))
						0: add_byte(CODE_LF);
						1: add_byte(CODE_NUL);
						default: add_byte(8'($urandom_range(255)));
					endcase
				end
				FR_IAC_NOP: begin
					add_byte(CODE_IAC);
					add_byte(CODE_NOP);
				end
				FR_IAC_IAC: begin
					add_byte(CODE_IAC);
					add_byte(CODE_IAC);
				end
				FR_NAWS: begin
					add_byte(CODE_IAC);
					add_byte(CODE_SB);
					add_byte(CODE_NAWS);
					repeat (NAWS_PAYLOAD) add_byte(8'($urandom_range(255)));
				end
				FR_SB_OTHER: begin
					add_byte(CODE_IAC);
					add_byte(CODE_SB);
					do b = 8'($urandom_range(255)); while (b == CODE_NAWS);
					add_byte(b);
				end
				FR_IAC_CMD: begin
					add_byte(CODE_IAC);
					do b = 8'($urandom_range(255));
					while (b == CODE_IAC || b == CODE_NOP || b == CODE_SB);
					add_byte(b);
					add_byte(8'($urandom_range(255)));
				end
				default: begin
					n = $urandom_range(1, 4);
					repeat (n) add_byte(8'($urandom_range(255)));
				end
			endcase
		end
	endtask

	// hold off the sender until every byte went in and every result came out
	task automatic drain();
		while (bytes_taken != bytes_queued || filtered_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || byte_taken) begin
				byte_taken = 1'b0;
				if (rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_byte = rx_stream_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_byte.rx_byte;
					s_tlast  <= cur_byte.buffer_last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: transfers sampled on the rising edge
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			stuck_cycles++;
			if (s_tvalid && s_tready) begin
				filter_byte(cur_byte);
				byte_taken   = 1'b1;
				bytes_taken++;
				stuck_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				stuck_cycles = 0;
				if (filtered_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: byte=%02h valid=%0d done=%0d total=%0d",
							m_tdata[7:0], m_tuser, m_tlast, m_tdata[18:8]);
				end else begin
					exp_r = filtered_q.pop_front();
					if (m_tdata[7:0] !== exp_r.data_byte || m_tuser !== exp_r.data_valid ||
						m_tlast !== exp_r.buffer_done || m_tdata[18:8] !== exp_r.kept_total) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: exp %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
								exp_r.data_byte, exp_r.data_valid, exp_r.buffer_done,
								exp_r.kept_total, m_tdata[7:0], m_tuser, m_tlast,
								m_tdata[18:8]);
					end
				end
			end
			// watchdog on cycles without any transfer
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: extremes, CR pairs, IAC commands, NAWS, buffer ends
		push_byte(CODE_NUL, 1'b0);
		push_byte(8'hFE, 1'b0);
		push_byte(CODE_CR, 1'b0);
		push_byte(CODE_LF, 1'b0);
		push_byte(CODE_CR, 1'b0);
		push_byte(CODE_NUL, 1'b0);
		push_byte(CODE_IAC, 1'b0);
		push_byte(CODE_NOP, 1'b0);
		push_byte(CODE_IAC, 1'b0);
		push_byte(CODE_IAC, 1'b0);
		push_byte(CODE_IAC, 1'b0);
		push_byte(CODE_SB, 1'b0);
		push_byte(CODE_NAWS, 1'b0);
		push_byte(CODE_IAC, 1'b0);
		push_byte(CODE_CR, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h50, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h18, 1'b0);
		push_byte(CODE_IAC, 1'b0);
		push_byte(8'hFB, 1'b0);
		push_byte(8'h01, 1'b0);
		// CR at buffer end must not eat the LF that opens the next buffer
		push_byte(CODE_CR, 1'b1);
		push_byte(CODE_LF, 1'b0);
		// open IAC cut off by the buffer end
		push_byte(CODE_IAC, 1'b1);

		// one long buffer that carries the kept count past the byte range
		repeat (300) push_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
		push_byte(8'h41, 1'b1);

		gen_random(106);
		drain();

		send_idle_pct = 77;
		gen_random(106);
		drain();

		send_idle_pct  = 0;
		recv_stall_pct = 77;
		gen_random(106);
		drain();

		send_idle_pct  = 17;
		recv_stall_pct = 17;
		gen_random(106);
		drain();

		if (mismatches == 0 && filtered_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
